// ----- design/cmq_pkg.sv -----
package cmq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = 7;
  localparam int CONN_W      = 31;
  localparam int WK_W        = 8;
  localparam int MODE_W      = 2;
  localparam int STAT_W      = 2;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 56;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam mode_t MODE_SCHED = 2'd0;
  localparam mode_t MODE_DISP  = 2'd1;
  localparam mode_t MODE_READ  = 2'd2;

  localparam stat_t ST_APPENDED = 2'd0;
  localparam stat_t ST_UPDATED  = 2'd1;
  localparam stat_t ST_DROPPED  = 2'd2;
  localparam stat_t ST_NONE     = 2'd3;

  typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic [WK_W-1:0]   src;
    logic [WK_W-1:0]   dst;
  } entry_t;

  typedef struct packed {
    logic cap;
    logic idx_inc;
    logic rd_en;
    logic upd_wr;
    logic app_wr;
    logic drop;
    logic disp;
    logic ld_out;
    logic ld_entry;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  idx_at_cnt;
    logic  idx_last;
    logic  hit;
    logic  full;
    logic  cnt_zero;
    logic  out_free;
  } sts_t;

endpackage

// ----- design/cmq_datapath.sv -----
module cmq_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cmq_pkg::cmd_t                     cmd,
  output cmq_pkg::sts_t                     sts,
  input  logic [cmq_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [cmq_pkg::MODE_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cmq_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [0:0]                        out_tuser,
  output logic                              out_tlast
);

  localparam int SUM_W = cmq_pkg::CNT_W + 1;

  function automatic cmq_pkg::ptr_t ptr_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    begin
      t = (s >= SUM_W'(cmq_pkg::QUEUE_DEPTH)) ? s - SUM_W'(cmq_pkg::QUEUE_DEPTH) : s;
      return t[cmq_pkg::PTR_W-1:0];
    end
  endfunction

  cmq_pkg::entry_t mem [cmq_pkg::QUEUE_DEPTH];

  cmq_pkg::mode_t           mode_r;
  cmq_pkg::entry_t          item_r;
  cmq_pkg::cnt_t            dc_r;
  cmq_pkg::ptr_t            head_r, head_nxt;
  cmq_pkg::cnt_t            cnt_r, cnt_nxt;
  cmq_pkg::cnt_t            idx_r, idx_nxt;
  cmq_pkg::entry_t          rdata_r;
  cmq_pkg::stat_t           status_r, status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ent_r;
  cmq_pkg::entry_t          out_item_r;
  logic                     out_last_r;
  cmq_pkg::cnt_t            out_cnt_r;
  cmq_pkg::stat_t           out_stat_r;
  cmq_pkg::ptr_t            addr;
  logic                     out_free;

  assign addr     = ptr_wrap(SUM_W'(head_r) + SUM_W'(idx_r));
  assign out_free = !out_valid_r || out_tready;

  assign sts.mode       = mode_r;
  assign sts.idx_at_cnt = (idx_r == cnt_r);
  assign sts.idx_last   = (SUM_W'(idx_r) + SUM_W'(1) == SUM_W'(cnt_r));
  assign sts.hit        = (rdata_r.conn == item_r.conn);
  assign sts.full       = (cnt_r == cmq_pkg::CNT_W'(cmq_pkg::QUEUE_DEPTH));
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.upd_wr || cmd.app_wr) begin
      mem[addr] <= item_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r       <= in_tuser;
      item_r.conn  <= in_tdata[30:0];
      item_r.src   <= in_tdata[38:31];
      item_r.dst   <= in_tdata[46:39];
      dc_r         <= in_tdata[53:47];
    end
    if (cmd.ld_out) begin
      out_ent_r  <= cmd.ld_entry;
      out_item_r <= cmd.ld_entry ? rdata_r : '0;
      out_last_r <= cmd.ld_entry ? sts.idx_last : 1'b1;
      out_cnt_r  <= cnt_r;
      out_stat_r <= status_r;
    end
  end

  always_comb begin
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    if (cmd.cap) begin
      idx_nxt    = '0;
      status_nxt = cmq_pkg::ST_NONE;
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_r + cmq_pkg::CNT_W'(1);
    end
    if (cmd.upd_wr) begin
      status_nxt = cmq_pkg::ST_UPDATED;
    end
    if (cmd.app_wr) begin
      cnt_nxt    = cnt_r + cmq_pkg::CNT_W'(1);
      status_nxt = cmq_pkg::ST_APPENDED;
    end
    if (cmd.drop) begin
      status_nxt = cmq_pkg::ST_DROPPED;
    end
    if (cmd.disp) begin
      if (dc_r >= cnt_r) begin
        cnt_nxt  = '0;
        head_nxt = '0;
      end else begin
        cnt_nxt  = cnt_r - dc_r;
        head_nxt = ptr_wrap(SUM_W'(head_r) + SUM_W'(dc_r));
      end
    end
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      status_r    <= cmq_pkg::ST_NONE;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ent_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_stat_r, out_cnt_r, out_item_r.dst, out_item_r.src, out_item_r.conn};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cmq_pkg::CNT_W'(cmq_pkg::QUEUE_DEPTH))
    else $error("pending count exceeds queue depth");

  a_app_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.app_wr |-> !sts.full)
    else $error("append into full queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> out_free)
    else $error("output beat overwritten before taken");

  a_upd_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_wr |-> sts.hit && !sts.idx_at_cnt)
    else $error("in-place update without matching entry");

endmodule

// ----- design/cmq_ctrl.sv -----
module cmq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cmq_pkg::sts_t sts,
  output cmq_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DEC  = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_CMP  = 8'b0000_1000,
    S_DISP = 8'b0001_0000,
    S_EMIT = 8'b0010_0000,
    S_RD   = 8'b0100_0000,
    S_RDW  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.mode)
          cmq_pkg::MODE_SCHED: state_nxt = S_SCAN;
          cmq_pkg::MODE_DISP:  state_nxt = S_DISP;
          cmq_pkg::MODE_READ:  state_nxt = sts.cnt_zero ? S_EMIT : S_RD;
          default:             state_nxt = S_EMIT;
        endcase
      end
      S_SCAN: begin
        if (sts.idx_at_cnt) begin
          cmd.drop   = sts.full;
          cmd.app_wr = !sts.full;
          state_nxt  = S_EMIT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.upd_wr = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_DISP: begin
        cmd.disp  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        if (sts.out_free) begin
          cmd.ld_out   = 1'b1;
          cmd.ld_entry = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/coalescing_move_queue_unit.sv -----
// Schedule: the table is searched entry by entry, one table read and one compare per entry;
// a matching entry is updated in place, else the item is appended, or dropped if full.
// Dispatch retires entries; readout: one beat per entry; unused mode, empty readout: one beat.
// One item in flight; the next beat is taken once the result sits in the output register.
// Reset clears count, head and output valid; table contents stay undefined.
module coalescing_move_queue_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // conn_id, src_worker, dst_worker, dispatch_count, zero pad
  input  logic [cmq_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode
  input  logic [cmq_pkg::MODE_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // entry_conn, entry_src, entry_dst, pending_count, status
  output logic [cmq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // entry_valid
  output logic [0:0]                        out_tuser,
  output logic                              out_tlast
);

  cmq_pkg::cmd_t cmd;
  cmq_pkg::sts_t sts;

  cmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cmq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- verif/tb_coalescing_move_queue_unit.sv -----
module tb_coalescing_move_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cmq_pkg::*;

  localparam mode_t MODE_UNUSED    = 2'd3;
  localparam int    DIR_ROWS       = 21;
  localparam int    RAND_ITEMS     = 440;
  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    DRAIN_CYCLES   = 150;

  typedef struct packed {
    logic              ev;
    logic [CONN_W-1:0] conn;
    logic [WK_W-1:0]   src;
    logic [WK_W-1:0]   dst;
    logic              last;
    cnt_t              cnt;
    stat_t             st;
  } beat_t;

  typedef struct packed {
    mode_t             mode;
    logic [CONN_W-1:0] conn;
    logic [WK_W-1:0]   src;
    logic [WK_W-1:0]   dst;
    logic [CNT_W-1:0]  n;
    logic              typed;
    cnt_t              cnt;
    stat_t             st;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;

  entry_t   pending_moves[$];
  beat_t    due_beats[$];
  dir_row_t dir_rows[DIR_ROWS];
  int       mismatch_count;
  int       sent_beats;
  int       idle_cycles;
  bit       steady;

  coalescing_move_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void predict_moves(mode_t m, logic [CONN_W-1:0] c, logic [WK_W-1:0] s,
                                        logic [WK_W-1:0] d, logic [CNT_W-1:0] n);
    beat_t  b;
    entry_t e;
    int     hit;
    b = '0;
    b.last = 1'b1;
    b.st = ST_NONE;
    hit = -1;
    case (m)
      MODE_SCHED: begin
        foreach (pending_moves[k]) begin
          if (hit < 0 && pending_moves[k].conn == c) hit = k;
        end
        if (hit >= 0) begin
          pending_moves[hit].src = s;
          pending_moves[hit].dst = d;
          b.st = ST_UPDATED;
        end else if (pending_moves.size() < QUEUE_DEPTH) begin
          e.conn = c;
          e.src = s;
          e.dst = d;
          pending_moves = {pending_moves, e};
          b.st = ST_APPENDED;
        end else begin
          b.st = ST_DROPPED;
        end
        b.cnt = cnt_t'(pending_moves.size());
        due_beats = {due_beats, b};
      end
      MODE_DISP: begin
        if (n >= pending_moves.size()) pending_moves.delete();
        else repeat (n) void'(pending_moves.pop_front());
        b.cnt = cnt_t'(pending_moves.size());
        due_beats = {due_beats, b};
      end
      MODE_READ: begin
        b.cnt = cnt_t'(pending_moves.size());
        if (pending_moves.size() == 0) begin
          due_beats = {due_beats, b};
        end else begin
          foreach (pending_moves[k]) begin
            b.ev = 1'b1;
            b.conn = pending_moves[k].conn;
            b.src = pending_moves[k].src;
            b.dst = pending_moves[k].dst;
            b.last = (k == pending_moves.size() - 1);
            due_beats = {due_beats, b};
          end
        end
      end
      default: begin
        b.cnt = cnt_t'(pending_moves.size());
        due_beats = {due_beats, b};
      end
    endcase
  endfunction

  task automatic send_move(input mode_t m, input logic [CONN_W-1:0] c, input logic [WK_W-1:0] s,
                           input logic [WK_W-1:0] d, input logic [CNT_W-1:0] n,
                           input bit typed, input cnt_t tcnt, input stat_t tst);
    beat_t b;
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {2'b00, n, d, s, c};
    do @(posedge clk); while (!in_tready);
    predict_moves(m, c, s, d, n);
    if (typed) begin
      b = due_beats.pop_back();
      b.cnt = tcnt;
      b.st = tst;
      due_beats = {due_beats, b};
    end
    sent_beats++;
    @(negedge clk);
  endtask

  task automatic send_random(input mode_t m);
    logic [CONN_W-1:0] c;
    logic [CNT_W-1:0]  n;
    c = CONN_W'($urandom);
    if (m == MODE_SCHED && pending_moves.size() > 0 && $urandom_range(0, 1) == 1)
      c = pending_moves[$urandom_range(0, pending_moves.size() - 1)].conn;
    n = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(0, 4)) : CNT_W'($urandom_range(0, 127));
    send_move(m, c, WK_W'($urandom_range(0, 255)), WK_W'($urandom_range(0, 255)), n,
              1'b0, '0, ST_NONE);
  endtask

  task automatic fill_queue();
    while (pending_moves.size() < QUEUE_DEPTH) send_random(MODE_SCHED);
    repeat (4) send_random(MODE_SCHED);
    send_random(MODE_READ);
    send_random(MODE_DISP);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (due_beats.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_beats.size() == 0) begin
        $error("unexpected result beat: tdata %0h tuser %0b tlast %0b",
               out_tdata, out_tuser, out_tlast);
        mismatch_count++;
      end else begin
        want = due_beats.pop_front();
        compare_field("entry_valid", want.ev, out_tuser[0]);
        compare_field("entry_conn", want.conn, out_tdata[30:0]);
        compare_field("entry_src", want.src, out_tdata[38:31]);
        compare_field("entry_dst", want.dst, out_tdata[46:39]);
        compare_field("last", want.last, out_tlast);
        compare_field("pending_count", want.cnt, out_tdata[53:47]);
        compare_field("status", want.st, out_tdata[55:54]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int    r;
    mode_t m;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    mismatch_count = 0;
    sent_beats     = 0;
    steady         = 1'b0;
    dir_rows = '{
      '{MODE_READ,   31'h0,        8'h00, 8'h00, 7'd0,   1'b1, 7'd0, ST_NONE},
      '{MODE_DISP,   31'h0,        8'h00, 8'h00, 7'd0,   1'b1, 7'd0, ST_NONE},
      '{MODE_UNUSED, 31'h0,        8'h00, 8'h00, 7'd0,   1'b1, 7'd0, ST_NONE},
      '{MODE_SCHED,  31'h7FFFFFFF, 8'hFF, 8'h00, 7'd0,   1'b1, 7'd1, ST_APPENDED},
      '{MODE_SCHED,  31'h0,        8'h00, 8'hFF, 7'd127, 1'b1, 7'd2, ST_APPENDED},
      '{MODE_SCHED,  31'h7FFFFFFF, 8'h12, 8'h34, 7'd0,   1'b1, 7'd2, ST_UPDATED},
      '{MODE_SCHED,  31'h2AAAAAAA, 8'hA5, 8'h5A, 7'd0,   1'b1, 7'd3, ST_APPENDED},
      '{MODE_SCHED,  31'h55555555, 8'h5A, 8'hA5, 7'd0,   1'b1, 7'd4, ST_APPENDED},
      '{MODE_READ,   31'h0,        8'h00, 8'h00, 7'd0,   1'b0, 7'd0, ST_NONE},
      '{MODE_DISP,   31'h0,        8'h00, 8'h00, 7'd0,   1'b1, 7'd4, ST_NONE},
      '{MODE_DISP,   31'h0,        8'h00, 8'h00, 7'd1,   1'b1, 7'd3, ST_NONE},
      '{MODE_SCHED,  31'h0,        8'h77, 8'h88, 7'd0,   1'b1, 7'd3, ST_UPDATED},
      '{MODE_READ,   31'h0,        8'h00, 8'h00, 7'd0,   1'b0, 7'd0, ST_NONE},
      '{MODE_UNUSED, 31'h7FFFFFFF, 8'hFF, 8'hFF, 7'd127, 1'b1, 7'd3, ST_NONE},
      '{MODE_DISP,   31'h0,        8'h00, 8'h00, 7'd127, 1'b1, 7'd0, ST_NONE},
      '{MODE_READ,   31'h0,        8'h00, 8'h00, 7'd0,   1'b1, 7'd0, ST_NONE},
      '{MODE_SCHED,  31'h1,        8'h01, 8'h02, 7'd0,   1'b1, 7'd1, ST_APPENDED},
      '{MODE_SCHED,  31'h2,        8'h03, 8'h04, 7'd0,   1'b1, 7'd2, ST_APPENDED},
      '{MODE_DISP,   31'h0,        8'h00, 8'h00, 7'd64,  1'b1, 7'd0, ST_NONE},
      '{MODE_SCHED,  31'h3,        8'h80, 8'h01, 7'd0,   1'b1, 7'd1, ST_APPENDED},
      '{MODE_DISP,   31'h0,        8'h00, 8'h00, 7'd1,   1'b1, 7'd0, ST_NONE}
    };
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_move(dir_rows[i].mode, dir_rows[i].conn, dir_rows[i].src, dir_rows[i].dst,
                dir_rows[i].n, dir_rows[i].typed, dir_rows[i].cnt, dir_rows[i].st);
    end
    hold_until_drained();

    fill_queue();
    while (sent_beats < DIR_ROWS + RAND_ITEMS) begin
      steady = (sent_beats >= 200 && sent_beats < 280);
      r = $urandom_range(0, 99);
      if (r < 2) begin
        fill_queue();
      end else if (r < 4) begin
        hold_until_drained();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) m = MODE_SCHED;
        else if (r < 78) m = MODE_DISP;
        else if (r < 95) m = MODE_READ;
        else m = MODE_UNUSED;
        send_random(m);
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (due_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_beats.size() != 0) begin
      $error("result beats still outstanding: %0d", due_beats.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cmq_pkg.sv
design/cmq_datapath.sv
design/cmq_ctrl.sv
design/coalescing_move_queue_unit.sv
verif/tb_coalescing_move_queue_unit.sv
